/* design/sha256_byte_stream_hasher_assert.svh */
// assertion macros for the byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/sha_pkg.sv */
// shared constants, types and the rotate helper for the sha-256 hasher
`default_nettype none
package sha_pkg;
    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

/* design/sha_fifo.sv */
// small item queue between the front end and the hashing engine
`default_nettype none
module sha_fifo #(
    parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sha_pkg::t_item     i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output sha_pkg::t_item     o_item
);
    import sha_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end
endmodule
`default_nettype wire

/* design/sha_engine.sv */
// byte gathering, padding, 64-round compression and digest output
`default_nettype none
module sha_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  sha_pkg::t_item     i_item,
    output logic               o_take,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    import sha_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_ZERO = 6'b000100,
        S_LEN  = 6'b001000,
        S_COMP = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    t_state        r_ret;
    logic [31:0]   r_h [8];
    logic [31:0]   r_v [8];
    logic [31:0]   r_w [16];
    logic [5:0]    r_fill;
    logic [60:0]   r_cnt;
    logic [5:0]    r_rnd;
    logic [2:0]    r_len;
    logic [2:0]    r_oidx;

    logic          w_push;
    logic [7:0]    w_byte;
    logic [63:0]   w_bits;
    logic [31:0]   w_s0, w_s1, w_wnew, w_t1, w_t2, w_wi;

    assign w_bits = {r_cnt, 3'b000};
    assign o_take = (r_state == S_IDLE) && i_valid;
    assign o_empty = (r_state != S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_comb begin
        w_push = 1'b0;
        w_byte = 8'h00;
        case (r_state)
            S_IDLE: begin
                w_push = o_take && i_item.has_byte;
                w_byte = i_item.data_byte;
            end
            S_PAD: begin
                w_push = 1'b1;
                w_byte = PadByte;
            end
            S_ZERO: begin
                w_push = (r_fill != LenStart);
            end
            S_LEN: begin
                w_push = 1'b1;
                w_byte = w_bits[8*(7 - r_len) +: 8];
            end
            default: ;
        endcase
    end

    // message schedule: r_w holds w[i..i+15]
    assign w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_wi = r_w[0];
    assign w_t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[r_rnd] + w_wi;
    assign w_t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_push && r_fill == 6'd63) begin
                    n_state = S_COMP;
                end else if (o_take && i_item.end_of_message) begin
                    n_state = S_PAD;
                end
            end
            S_PAD: n_state = (r_fill == 6'd63) ? S_COMP : S_ZERO;
            S_ZERO: begin
                if (r_fill == LenStart) begin
                    n_state = S_LEN;
                end else if (r_fill == 6'd63) begin
                    n_state = S_COMP;
                end
            end
            S_LEN: n_state = (r_len == 3'd7) ? S_COMP : S_LEN;
            S_COMP: begin
                if (r_rnd == 6'd63) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (i_pop && r_oidx == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_w[r_fill[5:2]][8*(3 - r_fill[1:0]) +: 8] <= w_byte;
        end
        if (r_state == S_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wnew;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end else begin
            r_v <= r_h;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_h     <= InitH;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_len   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == S_IDLE && o_take) begin
                if (i_item.has_byte) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_LEN) begin
                r_len <= r_len + 1'b1;
            end
            if (n_state == S_COMP && r_state != S_COMP) begin
                r_rnd <= '0;
                case (r_state)
                    S_IDLE: r_ret <= (i_item.end_of_message) ? S_PAD : S_IDLE;
                    S_PAD:  r_ret <= S_ZERO;
                    S_ZERO: r_ret <= S_ZERO;
                    S_LEN:  r_ret <= S_OUT;
                    default: r_ret <= S_IDLE;
                endcase
            end else if (r_state == S_COMP) begin
                r_rnd <= r_rnd + 1'b1;
                if (r_rnd == 6'd63) begin
                    r_h[0] <= r_h[0] + w_t1 + w_t2;
                    r_h[1] <= r_h[1] + r_v[0];
                    r_h[2] <= r_h[2] + r_v[1];
                    r_h[3] <= r_h[3] + r_v[2];
                    r_h[4] <= r_h[4] + r_v[3] + w_t1;
                    r_h[5] <= r_h[5] + r_v[4];
                    r_h[6] <= r_h[6] + r_v[5];
                    r_h[7] <= r_h[7] + r_v[6];
                end
            end
            if (r_state == S_OUT && i_pop) begin
                r_oidx <= r_oidx + 1'b1;
                if (r_oidx == 3'd7) begin
                    r_h   <= InitH;
                    r_cnt <= '0;
                    r_fill <= '0;
                    r_len <= '0;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* design/sha256_byte_stream_hasher.sv */
// Streaming SHA-256 over bytes. Items enter a 4-deep queue; the engine takes
// one queued item per cycle while it is gathering bytes. Each full 64-byte
// block is then compressed one round per cycle, during which no items are taken
// and the queue can fill until full rises. An end-of-message item pads up to
// offset 56, writes eight length bytes, compresses (once or twice), then
// presents eight digest words; the next message starts after word 7 is popped.
`default_nettype none
module sha256_byte_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import sha_pkg::*;

    t_item w_in, w_q;
    logic  w_qempty, w_take;

    assign w_in = '{data_byte: i_data_byte, has_byte: i_has_byte,
                    end_of_message: i_end_of_message};

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(w_in),
        .o_full(full), .i_pop(w_take), .o_empty(w_qempty), .o_item(w_q)
    );

    sha_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!w_qempty), .i_item(w_q),
        .o_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );
endmodule
`default_nettype wire

/* design/sha_checker.sv */
// port-level checks for the byte stream hasher
`default_nettype none
module sha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);
`include "sha256_byte_stream_hasher_assert.svh"
    `SHA_ASSERT_IMP(a_last, i_clk, i_rst_n, !empty, o_last_word == (o_word_index == 3'd7))
    `SHA_ASSERT_NXT(a_adv, i_clk, i_rst_n, !empty && pop && !o_last_word, !empty)
    `SHA_ASSERT_NXT(a_done, i_clk, i_rst_n, !empty && pop && o_last_word, empty)
    `SHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_word_index))
endmodule

bind sha256_byte_stream_hasher sha_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_word_index(o_word_index), .o_last_word(o_last_word)
);
`default_nettype wire
